[design/ugbt_pkg.sv]
`timescale 1ns / 1ps

package ugbt_pkg;

	localparam int GRID_SIDE  = 16;
	localparam int CELL_SLOTS = 16;
	localparam int NCELLS     = GRID_SIDE * GRID_SIDE;
	localparam int NSLOTS     = NCELLS * CELL_SLOTS;

	localparam int XW  = $clog2(GRID_SIDE);
	localparam int CW  = $clog2(NCELLS);
	localparam int SW  = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
	localparam int FW  = $clog2(CELL_SLOTS + 1);
	localparam int AW  = $clog2(NSLOTS);
	localparam int QW  = $clog2(GRID_SIDE + 1);
	localparam int QBW = $clog2(QW);
	localparam int DW  = 33 + $clog2(GRID_SIDE) + 1;

	localparam int REC_W   = 320;
	localparam int IN_W    = 384;
	localparam int OUT_W   = 24;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 32;

	localparam int STATUS_W = 2;
	localparam int CELLN_W  = 8;
	localparam int SLOTN_W  = 4;
	localparam int FILLA_W  = 5;

	localparam logic [CFG_IW-1:0] REG_MIN_X = 2'd0;
	localparam logic [CFG_IW-1:0] REG_MIN_Y = 2'd1;
	localparam logic [CFG_IW-1:0] REG_MAX_X = 2'd2;
	localparam logic [CFG_IW-1:0] REG_MAX_Y = 2'd3;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_OOB      = 2'd3
	} ugbt_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} ugbt_fstate_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_FRD,
		B_FCHK,
		B_SCAN,
		B_NEXT,
		B_SHRD,
		B_SHWR,
		B_RES
	} ugbt_bstate_t;

	typedef struct packed {
		logic             op;
		logic             oob;
		logic [XW-1:0]    cx;
		logic [XW-1:0]    cy;
		logic [REC_W-1:0] rec;
	} ugbt_item_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic valid;
	} ugbt_qctl_t;

	function automatic logic [CW-1:0] cell_of(input logic [XW-1:0] x, input logic [XW-1:0] y);
		cell_of = CW'(CW'(x) * CW'(GRID_SIDE) + CW'(y));
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] c, input logic [SW-1:0] s);
		slot_addr = AW'(AW'(c) * AW'(CELL_SLOTS) + AW'(s));
	endfunction

endpackage

[design/ugbt_front.sv]
`timescale 1ns / 1ps

module ugbt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [ugbt_pkg::IN_W-1:0]   s_axis_tdata,
	input  logic                        s_axis_tuser,
	input  logic                        cfg_we,
	input  logic [ugbt_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ugbt_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        q_full,
	output logic                        q_push,
	output ugbt_pkg::ugbt_item_t        q_item
);

	ugbt_pkg::ugbt_fstate_t state_q, state_d;

	logic signed [31:0] min_x_q, min_y_q, max_x_q, max_y_q;

	logic                          op_q, oob_q;
	logic [ugbt_pkg::REC_W-1:0]    rec_q;
	logic [ugbt_pkg::DW-1:0]       rem_x_q, rem_y_q;
	logic [32:0]                   dvs_x_q, dvs_y_q;
	logic [ugbt_pkg::QW-1:0]       qx_q, qy_q;
	logic [ugbt_pkg::QBW-1:0]      b_q;

	logic signed [32:0] px, py, off_x, off_y, rng_x, rng_y;
	logic               oob_in;
	logic [ugbt_pkg::DW-1:0] sh_x, sh_y;
	logic [ugbt_pkg::XW-1:0] cx, cy;

	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			min_y_q <= '0;
			max_x_q <= 32'sd65536;
			max_y_q <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				ugbt_pkg::REG_MIN_X: min_x_q <= cfg_data;
				ugbt_pkg::REG_MIN_Y: min_y_q <= cfg_data;
				ugbt_pkg::REG_MAX_X: max_x_q <= cfg_data;
				ugbt_pkg::REG_MAX_Y: max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		px    = 33'(signed'(s_axis_tdata[31:0]));
		py    = 33'(signed'(s_axis_tdata[63:32]));
		off_x = px - 33'(min_x_q);
		off_y = py - 33'(min_y_q);
		rng_x = 33'(max_x_q) - 33'(min_x_q);
		rng_y = 33'(max_y_q) - 33'(min_y_q);
		oob_in = (rng_x <= 0) || (off_x < 0) || (px > 33'(max_x_q)) ||
			(rng_y <= 0) || (off_y < 0) || (py > 33'(max_y_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ugbt_pkg::F_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ugbt_pkg::F_IDLE: if (s_axis_tvalid) state_d = ugbt_pkg::F_DIV;
			ugbt_pkg::F_DIV:  if (b_q == '0) state_d = ugbt_pkg::F_PUSH;
			ugbt_pkg::F_PUSH: if (!q_full) state_d = ugbt_pkg::F_IDLE;
			default:          state_d = ugbt_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		q_push        = 1'b0;
		case (state_q)
			ugbt_pkg::F_IDLE: s_axis_tready = 1'b1;
			ugbt_pkg::F_PUSH: q_push = !q_full;
			default: ;
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	assign sh_x = ugbt_pkg::DW'(dvs_x_q) << b_q;
	assign sh_y = ugbt_pkg::DW'(dvs_y_q) << b_q;

	// restoring division, one quotient bit per cycle on both axes
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_axis_tuser;
			oob_q   <= oob_in;
			rec_q   <= s_axis_tdata[ugbt_pkg::IN_W-1:64];
			rem_x_q <= ugbt_pkg::DW'(ugbt_pkg::DW'(off_x[31:0]) * ugbt_pkg::DW'(ugbt_pkg::GRID_SIDE));
			rem_y_q <= ugbt_pkg::DW'(ugbt_pkg::DW'(off_y[31:0]) * ugbt_pkg::DW'(ugbt_pkg::GRID_SIDE));
			dvs_x_q <= rng_x;
			dvs_y_q <= rng_y;
			qx_q    <= '0;
			qy_q    <= '0;
			b_q     <= ugbt_pkg::QBW'(ugbt_pkg::QW - 1);
		end else if (state_q == ugbt_pkg::F_DIV) begin
			if (rem_x_q >= sh_x) begin
				rem_x_q   <= rem_x_q - sh_x;
				qx_q[b_q] <= 1'b1;
			end
			if (rem_y_q >= sh_y) begin
				rem_y_q   <= rem_y_q - sh_y;
				qy_q[b_q] <= 1'b1;
			end
			if (b_q != '0) b_q <= b_q - 1'b1;
		end
	end

	always_comb begin
		cx = (qx_q > ugbt_pkg::QW'(ugbt_pkg::GRID_SIDE - 1)) ?
			ugbt_pkg::XW'(ugbt_pkg::GRID_SIDE - 1) : ugbt_pkg::XW'(qx_q);
		cy = (qy_q > ugbt_pkg::QW'(ugbt_pkg::GRID_SIDE - 1)) ?
			ugbt_pkg::XW'(ugbt_pkg::GRID_SIDE - 1) : ugbt_pkg::XW'(qy_q);
		q_item.op  = op_q;
		q_item.oob = oob_q;
		q_item.cx  = cx;
		q_item.cy  = cy;
		q_item.rec = rec_q;
	end

endmodule

[design/ugbt_queue.sv]
`timescale 1ns / 1ps

module ugbt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ugbt_pkg::ugbt_qctl_t ctl_in,
	output ugbt_pkg::ugbt_qctl_t ctl_out,
	input  ugbt_pkg::ugbt_item_t wr_item,
	output ugbt_pkg::ugbt_item_t rd_item
);

	ugbt_pkg::ugbt_item_t ent_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (ctl_in.push) wp_q <= !wp_q;
			if (ctl_in.pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(ctl_in.push) - 2'(ctl_in.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.push) ent_q[wp_q] <= wr_item;
	end

	always_comb begin
		ctl_out.push  = ctl_in.push;
		ctl_out.pop   = ctl_in.pop;
		ctl_out.full  = (cnt_q == 2'd2);
		ctl_out.valid = (cnt_q != 2'd0);
		rd_item       = ent_q[rp_q];
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_in.push |-> (cnt_q != 2'd2))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_in.pop |-> (cnt_q != 2'd0))
		else $error("queue pop while empty");

endmodule

[design/ugbt_back.sv]
`timescale 1ns / 1ps

module ugbt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  ugbt_pkg::ugbt_item_t       q_item,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [ugbt_pkg::OUT_W-1:0] m_axis_tdata
);

	ugbt_pkg::ugbt_bstate_t state_q, state_d;

	logic [ugbt_pkg::REC_W-1:0] slot_mem [ugbt_pkg::NSLOTS];
	logic [ugbt_pkg::FW-1:0]    fill_mem [ugbt_pkg::NCELLS];
	logic [ugbt_pkg::NCELLS-1:0] fill_vld_q;

	logic [ugbt_pkg::REC_W-1:0] slot_rd_q;
	logic [ugbt_pkg::FW-1:0]    fill_rd_q;
	logic                       fvld_rd_q;

	logic                       op_q;
	logic [ugbt_pkg::XW-1:0]    cx_q, cy_q;
	logic [ugbt_pkg::REC_W-1:0] rec_q;
	logic [ugbt_pkg::CW-1:0]    cell_q, home_q;
	logic                       at_home_q;
	logic [ugbt_pkg::FW-1:0]    n_q, home_fill_q;
	logic [ugbt_pkg::SW-1:0]    s_q, found_q;
	logic [1:0]                 i_q, j_q;

	ugbt_pkg::ugbt_status_t     res_st_q;
	logic [ugbt_pkg::CW-1:0]    res_cell_q;
	logic [ugbt_pkg::SW-1:0]    res_slot_q;
	logic [ugbt_pkg::FW-1:0]    res_fill_q;

	logic                       out_vld_q;
	logic [ugbt_pkg::OUT_W-1:0] out_q;

	logic                       slot_re, slot_we, fill_re, fill_we, out_load;
	logic [ugbt_pkg::AW-1:0]    slot_raddr, slot_waddr;
	logic [ugbt_pkg::REC_W-1:0] slot_wdata;
	logic [ugbt_pkg::CW-1:0]    fill_addr;
	logic [ugbt_pkg::FW-1:0]    fill_wdata;

	logic [ugbt_pkg::FW-1:0]    n_rd, s_next;
	logic                       id_hit, more;
	logic [ugbt_pkg::XW+1:0]    sx, sy;
	logic                       cand_ok;
	logic [ugbt_pkg::CW-1:0]    cand_cell;

	always_comb begin
		n_rd    = fvld_rd_q ? fill_rd_q : '0;
		s_next  = ugbt_pkg::FW'(s_q) + ugbt_pkg::FW'(1);
		more    = (s_next < n_q);
		id_hit  = (slot_rd_q[63:0] == rec_q[63:0]);
		sx      = (ugbt_pkg::XW+2)'(cx_q) + (ugbt_pkg::XW+2)'(i_q);
		sy      = (ugbt_pkg::XW+2)'(cy_q) + (ugbt_pkg::XW+2)'(j_q);
		cand_ok = (sx != '0) && (sx <= (ugbt_pkg::XW+2)'(ugbt_pkg::GRID_SIDE)) &&
			(sy != '0) && (sy <= (ugbt_pkg::XW+2)'(ugbt_pkg::GRID_SIDE)) &&
			!((i_q == 2'd1) && (j_q == 2'd1));
		cand_cell = ugbt_pkg::cell_of(ugbt_pkg::XW'(sx - 1'b1), ugbt_pkg::XW'(sy - 1'b1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ugbt_pkg::B_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ugbt_pkg::B_IDLE: begin
				if (q_valid) state_d = q_item.oob ? ugbt_pkg::B_RES : ugbt_pkg::B_FRD;
			end
			ugbt_pkg::B_FRD: state_d = ugbt_pkg::B_FCHK;
			ugbt_pkg::B_FCHK: begin
				if (op_q == ugbt_pkg::OP_ADD) state_d = ugbt_pkg::B_RES;
				else if (n_rd == '0)          state_d = ugbt_pkg::B_NEXT;
				else                          state_d = ugbt_pkg::B_SCAN;
			end
			ugbt_pkg::B_SCAN: begin
				if (id_hit)     state_d = ugbt_pkg::B_SHRD;
				else if (!more) state_d = ugbt_pkg::B_NEXT;
			end
			ugbt_pkg::B_NEXT: begin
				if (i_q == 2'd3)  state_d = ugbt_pkg::B_RES;
				else if (cand_ok) state_d = ugbt_pkg::B_FRD;
			end
			ugbt_pkg::B_SHRD: state_d = more ? ugbt_pkg::B_SHWR : ugbt_pkg::B_RES;
			ugbt_pkg::B_SHWR: state_d = ugbt_pkg::B_SHRD;
			ugbt_pkg::B_RES:  if (!out_vld_q || m_axis_tready) state_d = ugbt_pkg::B_IDLE;
			default:          state_d = ugbt_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		fill_re    = 1'b0;
		fill_we    = 1'b0;
		fill_addr  = cell_q;
		fill_wdata = '0;
		slot_re    = 1'b0;
		slot_raddr = ugbt_pkg::slot_addr(cell_q, ugbt_pkg::SW'(s_next));
		slot_we    = 1'b0;
		slot_waddr = ugbt_pkg::slot_addr(cell_q, s_q);
		slot_wdata = slot_rd_q;
		out_load   = 1'b0;
		case (state_q)
			ugbt_pkg::B_IDLE: q_pop = q_valid;
			ugbt_pkg::B_FRD:  fill_re = 1'b1;
			ugbt_pkg::B_FCHK: begin
				if (op_q == ugbt_pkg::OP_ADD) begin
					if (n_rd < ugbt_pkg::FW'(ugbt_pkg::CELL_SLOTS)) begin
						fill_we    = 1'b1;
						fill_wdata = n_rd + 1'b1;
						slot_we    = 1'b1;
						slot_waddr = ugbt_pkg::slot_addr(cell_q, ugbt_pkg::SW'(n_rd));
						slot_wdata = rec_q;
					end
				end else begin
					slot_re    = 1'b1;
					slot_raddr = ugbt_pkg::slot_addr(cell_q, '0);
				end
			end
			ugbt_pkg::B_SCAN: slot_re = !id_hit && more;
			ugbt_pkg::B_SHRD: begin
				if (more) begin
					slot_re = 1'b1;
				end else begin
					fill_we    = 1'b1;
					fill_wdata = n_q - 1'b1;
				end
			end
			ugbt_pkg::B_SHWR: slot_we = 1'b1;
			ugbt_pkg::B_RES:  out_load = !out_vld_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
		if (slot_re) slot_rd_q <= slot_mem[slot_raddr];
		if (fill_we) fill_mem[fill_addr] <= fill_wdata;
		if (fill_re) begin
			fill_rd_q <= fill_mem[fill_addr];
			fvld_rd_q <= fill_vld_q[fill_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)      fill_vld_q <= '0;
		else if (fill_we) fill_vld_q[fill_addr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ugbt_pkg::B_IDLE: begin
				op_q      <= q_item.op;
				cx_q      <= q_item.cx;
				cy_q      <= q_item.cy;
				rec_q     <= q_item.rec;
				cell_q    <= ugbt_pkg::cell_of(q_item.cx, q_item.cy);
				home_q    <= ugbt_pkg::cell_of(q_item.cx, q_item.cy);
				at_home_q <= 1'b1;
				i_q       <= '0;
				j_q       <= '0;
				res_st_q   <= ugbt_pkg::ST_OOB;
				res_cell_q <= '0;
				res_slot_q <= '0;
				res_fill_q <= '0;
			end
			ugbt_pkg::B_FCHK: begin
				n_q       <= n_rd;
				s_q       <= '0;
				at_home_q <= 1'b0;
				if (at_home_q) home_fill_q <= n_rd;
				res_cell_q <= cell_q;
				if (n_rd < ugbt_pkg::FW'(ugbt_pkg::CELL_SLOTS)) begin
					res_st_q   <= ugbt_pkg::ST_OK;
					res_slot_q <= ugbt_pkg::SW'(n_rd);
					res_fill_q <= n_rd + 1'b1;
				end else begin
					res_st_q   <= ugbt_pkg::ST_FULL;
					res_slot_q <= '0;
					res_fill_q <= n_rd;
				end
			end
			ugbt_pkg::B_SCAN: begin
				if (id_hit)    found_q <= s_q;
				else if (more) s_q <= ugbt_pkg::SW'(s_next);
			end
			ugbt_pkg::B_NEXT: begin
				if (i_q == 2'd3) begin
					res_st_q   <= ugbt_pkg::ST_NOTFOUND;
					res_cell_q <= home_q;
					res_slot_q <= '0;
					res_fill_q <= home_fill_q;
				end else begin
					if (cand_ok) cell_q <= cand_cell;
					if (j_q == 2'd2) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
			end
			ugbt_pkg::B_SHRD: begin
				if (!more) begin
					res_st_q   <= ugbt_pkg::ST_OK;
					res_cell_q <= cell_q;
					res_slot_q <= found_q;
					res_fill_q <= n_q - 1'b1;
				end
			end
			ugbt_pkg::B_SHWR: s_q <= ugbt_pkg::SW'(s_next);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            out_vld_q <= 1'b0;
		else if (out_load)      out_vld_q <= 1'b1;
		else if (m_axis_tready) out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= ugbt_pkg::OUT_W'({
				ugbt_pkg::FILLA_W'(res_fill_q),
				ugbt_pkg::SLOTN_W'(res_slot_q),
				ugbt_pkg::CELLN_W'(res_cell_q),
				res_st_q});
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> (fill_wdata <= ugbt_pkg::FW'(ugbt_pkg::CELL_SLOTS)))
		else $error("cell count written above capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ugbt_pkg::B_SCAN) |-> (ugbt_pkg::FW'(s_q) < n_q))
		else $error("slot scan past cell count");

endmodule

[design/uniform_grid_bucket_table.sv]
`timescale 1ns / 1ps

// Grid binning table: 16x16 cells of 16 slots. The front takes an item through
// the handshake, maps both coordinates with the restoring divider and pushes
// the item into the queue. In the back an add reads the cell count and writes
// the slot and the new count; a remove reads one slot id per cycle from the
// single slot memory port, scanning the occupied slots of each visited cell,
// up to nine cells, then shifts the later entries down.
// A two-entry queue lets the front map the next item while the back
// works. Cell counts are valid-bit backed and clear at reset; no clear pass.
module uniform_grid_bucket_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// pos_x, pos_y, mesh_id, program_id, instance_start, instance_count,
	// index_start, index_count, vertex_start, vertex_count
	input  logic [ugbt_pkg::IN_W-1:0]   s_axis_tdata,
	// op
	input  logic                        s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// status, cell_number, slot_number, fill_after, zero pad
	output logic [ugbt_pkg::OUT_W-1:0]  m_axis_tdata,
	input  logic                        cfg_we,
	input  logic [ugbt_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ugbt_pkg::CFG_DW-1:0] cfg_data
);

	ugbt_pkg::ugbt_item_t push_item, pop_item;
	ugbt_pkg::ugbt_qctl_t qctl_in, qctl_out;
	logic push, pop;

	ugbt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_full        (qctl_out.full),
		.q_push        (push),
		.q_item        (push_item)
	);

	always_comb begin
		qctl_in.push  = push;
		qctl_in.pop   = pop;
		qctl_in.full  = 1'b0;
		qctl_in.valid = 1'b0;
	end

	ugbt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (qctl_in),
		.ctl_out (qctl_out),
		.wr_item (push_item),
		.rd_item (pop_item)
	);

	ugbt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (qctl_out.valid),
		.q_pop         (pop),
		.q_item        (pop_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

[tb/sv/uniform_grid_bucket_table_test.sv]
`timescale 1ns / 1ps

module uniform_grid_bucket_table_test;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE      = 300;

	typedef struct packed {
		ugbt_pkg::ugbt_status_t st;
		logic [7:0]   cnum;
		logic [3:0]   slot;
		logic [4:0]   fill;
	} grid_result_t;

	typedef struct {
		logic                op;
		logic signed [31:0]  x;
		logic signed [31:0]  y;
		logic [63:0]         id;
		int                  reps;
		bit                  known;
		grid_result_t        res;
	} stim_row_t;

	typedef struct {
		logic [63:0]        id;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} placed_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [ugbt_pkg::IN_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [ugbt_pkg::OUT_W-1:0] m_axis_tdata;
	logic cfg_we = 0;
	logic [ugbt_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [ugbt_pkg::CFG_DW-1:0] cfg_data = '0;

	uniform_grid_bucket_table uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// shadow of the table
	logic signed [31:0] lo_x, lo_y, hi_x, hi_y;
	logic [63:0] cell_ids [ugbt_pkg::NCELLS][ugbt_pkg::CELL_SLOTS];
	int slot_fill [ugbt_pkg::NCELLS];
	grid_result_t pending_results [$];
	placed_t placed [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit calm = 0;

	function automatic bit axis_to_cell(input logic signed [31:0] p, lo, hi, output int c);
		longint span, off;
		span = longint'(hi) - longint'(lo);
		off = longint'(p) - longint'(lo);
		c = 0;
		if (span <= 0 || off < 0 || p > hi)
			return 0;
		c = int'((off * 16) / span);
		if (c > ugbt_pkg::GRID_SIDE - 1)
			c = ugbt_pkg::GRID_SIDE - 1;
		return 1;
	endfunction

	function automatic int slot_of_id(input int c, input logic [63:0] id);
		for (int s = 0; s < slot_fill[c]; s++)
			if (cell_ids[c][s] == id)
				return s;
		return ugbt_pkg::CELL_SLOTS;
	endfunction

	function automatic grid_result_t bin_entry(input logic op, input logic signed [31:0] x, y,
			input logic [63:0] id);
		grid_result_t r;
		int cx, cy, home, c, s, nx, ny;
		r = '{ugbt_pkg::ST_OK, 0, 0, 0};
		if (!axis_to_cell(x, lo_x, hi_x, cx) || !axis_to_cell(y, lo_y, hi_y, cy)) begin
			r.st = ugbt_pkg::ST_OOB;
			return r;
		end
		home = cx * ugbt_pkg::GRID_SIDE + cy;
		if (op == ugbt_pkg::OP_ADD) begin
			r.cnum = 8'(home);
			if (slot_fill[home] >= ugbt_pkg::CELL_SLOTS) begin
				r.st = ugbt_pkg::ST_FULL;
				r.fill = 5'(slot_fill[home]);
				return r;
			end
			cell_ids[home][slot_fill[home]] = id;
			r.slot = 4'(slot_fill[home]);
			slot_fill[home]++;
			r.fill = 5'(slot_fill[home]);
			return r;
		end
		c = home;
		s = slot_of_id(home, id);
		for (int dx = -1; dx <= 1 && s >= ugbt_pkg::CELL_SLOTS; dx++) begin
			nx = cx + dx;
			if (nx < 0 || nx >= ugbt_pkg::GRID_SIDE)
				continue;
			for (int dy = -1; dy <= 1; dy++) begin
				ny = cy + dy;
				if (ny < 0 || ny >= ugbt_pkg::GRID_SIDE || (dx == 0 && dy == 0))
					continue;
				c = nx * ugbt_pkg::GRID_SIDE + ny;
				s = slot_of_id(c, id);
				if (s < ugbt_pkg::CELL_SLOTS)
					break;
			end
		end
		if (s >= ugbt_pkg::CELL_SLOTS) begin
			r.st = ugbt_pkg::ST_NOTFOUND;
			r.cnum = 8'(home);
			r.fill = 5'(slot_fill[home]);
			return r;
		end
		for (int k = s; k < slot_fill[c] - 1; k++)
			cell_ids[c][k] = cell_ids[c][k + 1];
		slot_fill[c]--;
		r.cnum = 8'(c);
		r.slot = 4'(s);
		r.fill = 5'(slot_fill[c]);
		return r;
	endfunction

	// called at a rising edge; leaves the transfer done at a rising edge
	task automatic send_entry(input logic op, input logic signed [31:0] x, y,
			input logic [63:0] id, input bit known, input grid_result_t res);
		grid_result_t r;
		if (!calm && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, id, y, x};
		forever begin
			@(negedge clk);
			if (s_axis_tready)
				break;
		end
		@(posedge clk);
		r = bin_entry(op, x, y, id);
		if (known && r != res) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row: expected %p, got %p", res, r);
		end
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic set_bounds(input logic signed [31:0] mnx, mny, mxx, mxy);
		logic signed [31:0] v [4];
		v = '{mnx, mny, mxx, mxy};
		s_axis_tvalid <= 0;
		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1;
			cfg_index <= ugbt_pkg::CFG_IW'(i);
			cfg_data <= v[i];
			@(posedge clk);
		end
		cfg_we <= 0;
		lo_x = mnx;
		lo_y = mny;
		hi_x = mxx;
		hi_y = mxy;
	endtask

	function automatic logic signed [31:0] pick_coord(input logic signed [31:0] lo, hi);
		longint span, v;
		span = longint'(hi) - longint'(lo);
		if (span <= 0 || $urandom_range(99) < 10)
			return $urandom;
		v = longint'(lo) + (span * ($urandom_range(1) ? $urandom_range(3) : $urandom_range(13, 16))) / 16
			+ longint'({$urandom, $urandom} % (span / 16 + 1));
		if (v > longint'(hi))
			v = hi;
		return v[31:0];
	endfunction

	task automatic random_phase(input int n);
		placed_t p;
		int k;
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3 && i < n / 3 + 40);
			if ($urandom_range(99) < 45 && placed.size() > 0) begin
				k = $urandom_range(placed.size() - 1);
				p = placed[k];
				placed.delete(k);
				if ($urandom_range(1)) begin
					p.x = pick_coord(lo_x, hi_x);
					p.y = pick_coord(lo_y, hi_y);
				end
				if ($urandom_range(99) < 10)
					p.id = {$urandom, $urandom};
				send_entry(ugbt_pkg::OP_REMOVE, p.x, p.y, p.id, 0, '0);
			end else begin
				p.x = pick_coord(lo_x, hi_x);
				p.y = pick_coord(lo_y, hi_y);
				p.id = (placed.size() > 0 && $urandom_range(99) < 8) ?
					placed[$urandom_range(placed.size() - 1)].id : {$urandom, $urandom};
				placed.insert(placed.size(), p);
				send_entry(ugbt_pkg::OP_ADD, p.x, p.y, p.id, 0, '0);
			end
		end
		calm = 0;
	endtask

	always @(posedge clk)
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 12);

	always @(posedge clk) begin
		grid_result_t got, want;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.st = ugbt_pkg::ugbt_status_t'(m_axis_tdata[1:0]);
			got.cnum = m_axis_tdata[9:2];
			got.slot = m_axis_tdata[13:10];
			got.fill = m_axis_tdata[18:14];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		lo_x = 0;
		lo_y = 0;
		hi_x = 32'sh10000;
		hi_y = 32'sh10000;
		foreach (slot_fill[c])
			slot_fill[c] = 0;
		rows = '{
			'{ugbt_pkg::OP_ADD, 0, 0, 64'h0, 1, 1,
				'{ugbt_pkg::ST_OK, 8'd0, 4'd0, 5'd1}},
			'{ugbt_pkg::OP_ADD, 32'sh10000, 32'sh10000, '1, 1, 1,
				'{ugbt_pkg::ST_OK, 8'd255, 4'd0, 5'd1}},
			'{ugbt_pkg::OP_ADD, -1, 0, 64'h5, 1, 1,
				'{ugbt_pkg::ST_OOB, 8'd0, 4'd0, 5'd0}},
			'{ugbt_pkg::OP_ADD, 32'sh7fffffff, 32'sh80000000, 64'h6, 1, 1,
				'{ugbt_pkg::ST_OOB, 8'd0, 4'd0, 5'd0}},
			'{ugbt_pkg::OP_REMOVE, 32'sh80000000, 0, 64'h6, 1, 1,
				'{ugbt_pkg::ST_OOB, 8'd0, 4'd0, 5'd0}},
			'{ugbt_pkg::OP_REMOVE, 0, 0, 64'h77, 1, 1,
				'{ugbt_pkg::ST_NOTFOUND, 8'd0, 4'd0, 5'd1}},
			'{ugbt_pkg::OP_ADD, 0, 0, 64'hd, 15, 0, '0},
			'{ugbt_pkg::OP_ADD, 0, 0, 64'he, 1, 1,
				'{ugbt_pkg::ST_FULL, 8'd0, 4'd0, 5'd16}},
			'{ugbt_pkg::OP_REMOVE, 32'sh10000, 32'she000, '1, 1, 1,
				'{ugbt_pkg::ST_OK, 8'd255, 4'd0, 5'd0}},
			'{ugbt_pkg::OP_REMOVE, 32'sh1000, 32'sh1000, 64'h0, 1, 1,
				'{ugbt_pkg::ST_OK, 8'd0, 4'd0, 5'd15}},
			'{ugbt_pkg::OP_REMOVE, 0, 0, 64'hd, 1, 0, '0},
			'{ugbt_pkg::OP_ADD, 32'sh8000, 32'sh7fff, 64'h9, 1, 0, '0},
			'{ugbt_pkg::OP_REMOVE, 32'sh8000, 32'sh7fff, 64'h9, 1, 0, '0}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_bounds(0, 0, 32'sh10000, 32'sh10000);
		foreach (rows[i])
			repeat (rows[i].reps)
				send_entry(rows[i].op, rows[i].x, rows[i].y, rows[i].id,
					rows[i].known, rows[i].res);
		random_phase(180);
		set_bounds(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
		placed.delete();
		random_phase(180);
		set_bounds(-100, -5000, 100, 300000);
		placed.delete();
		random_phase(180);
		set_bounds(10, 10, 10, 5);
		random_phase(40);
		set_bounds(-3, 32'sh7ffffff0, 32'sh7fffffff, 32'sh7fffffff);
		placed.delete();
		random_phase(180);
		set_bounds(0, 0, 32'sh10000, 32'sh10000);
		placed.delete();
		random_phase(140);
		s_axis_tvalid <= 0;
		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[uniform_grid_bucket_table.f]
design/ugbt_pkg.sv
design/ugbt_front.sv
design/ugbt_queue.sv
design/ugbt_back.sv
design/uniform_grid_bucket_table.sv
tb/sv/uniform_grid_bucket_table_test.sv
